// ===== hw/rtl/vlc_pkg.sv =====
// Package: shared constants, types and the per-slot format function of the layout cache.
`timescale 1ns / 1ps
`default_nettype none
package vlc_pkg;

   localparam int VLC_TABLE_ENTRIES = 256;
   localparam int VLC_NUM_SLOTS     = 13;
   localparam int VLC_WALK_LEN      = 12;

   // status codes
   localparam logic [1:0] STATUS_FOUND = 2'd0;
   localparam logic [1:0] STATUS_ADDED = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // element types
   localparam logic [1:0] ELEM_UBYTE = 2'd0;
   localparam logic [1:0] ELEM_FLOAT = 2'd1;
   localparam logic [1:0] ELEM_HALF  = 2'd2;

   // slot numbers
   localparam logic [3:0] SLOT_SEPARATE = 4'd12;

   // descriptor flag masks
   localparam logic [31:0] M_S3_PACKED = 32'h0088_0008;
   localparam logic [31:0] M_S3_FLOAT  = 32'h0000_0004;
   localparam logic [31:0] M_S4_PACKED = 32'h0100_0020;
   localparam logic [31:0] M_S4_FLOAT  = 32'h0000_0010;
   localparam logic [31:0] M_S5_PACKED = 32'h0200_0080;
   localparam logic [31:0] M_S5_FLOAT  = 32'h0000_0040;
   localparam logic [31:0] M_S1        = 32'h0000_0100;
   localparam logic [31:0] M_S2        = 32'h0000_0600;
   localparam logic [31:0] M_TEX_HALF  = 32'h0800_0000;
   localparam logic [31:0] M_S10_PACK  = 32'h0000_8000;
   localparam logic [31:0] M_S10_FLT   = 32'h0000_4000;
   localparam logic [31:0] M_S11_PACK  = 32'h0002_0000;
   localparam logic [31:0] M_S11_FLT   = 32'h0001_0000;
   localparam logic [31:0] M_S8_S9     = 32'h0400_0000;
   localparam logic [31:0] M_S12       = 32'h0040_0000;

   // order in which offsets are assigned
   localparam logic [3:0] WALK_ORDER [VLC_WALK_LEN] = '{
      4'd0, 4'd3, 4'd4, 4'd5, 4'd1, 4'd2, 4'd6, 4'd7, 4'd10, 4'd11, 4'd8, 4'd9
   };

   typedef struct packed {
      logic       on;
      logic [1:0] elem_type;
      logic [2:0] comps;
      logic       norm;
      logic [4:0] size;
   } slot_fmt_type;

   typedef struct packed {
      logic [1:0] elem_type;
      logic [2:0] comps;
      logic       norm;
      logic [6:0] offset;
   } slot_rec_type;

   // layout unit status toward the control
   typedef struct packed {
      logic                     busy;
      logic [VLC_NUM_SLOTS-1:0] en;
      logic [6:0]               stride;
      slot_rec_type             rec;
   } lay_stat_type;

   function automatic slot_fmt_type fmt(input logic on, input logic [1:0] et,
                                        input logic [2:0] c, input logic n,
                                        input logic [4:0] sz);
      slot_fmt_type f;
      f.on = on; f.elem_type = et; f.comps = c; f.norm = n; f.size = sz;
      return f;
   endfunction

   // format of one slot as a pure function of the descriptor
   function automatic slot_fmt_type slot_fmt(input logic [31:0] d, input logic [3:0] s);
      slot_fmt_type f;
      logic [2:0]   mode;
      logic         half;
      mode = d[13:11];
      half = |(d & M_TEX_HALF);
      f    = '0;
      case (s)
         4'd0: f = fmt(1'b1, ELEM_FLOAT, 3'd3, 1'b0, 5'd12);
         4'd3: begin
            if (|(d & M_S3_PACKED)) f = fmt(1'b1, ELEM_UBYTE, 3'd4, 1'b1, 5'd4);
            else if (|(d & M_S3_FLOAT)) f = fmt(1'b1, ELEM_FLOAT, 3'd3, 1'b0, 5'd12);
         end
         4'd4: begin
            if (|(d & M_S4_PACKED)) f = fmt(1'b1, ELEM_UBYTE, 3'd4, 1'b1, 5'd4);
            else if (|(d & M_S4_FLOAT)) f = fmt(1'b1, ELEM_FLOAT, 3'd3, 1'b0, 5'd12);
         end
         4'd5: begin
            if (|(d & M_S5_PACKED)) f = fmt(1'b1, ELEM_UBYTE, 3'd4, 1'b1, 5'd4);
            else if (|(d & M_S5_FLOAT)) f = fmt(1'b1, ELEM_FLOAT, 3'd3, 1'b0, 5'd12);
         end
         4'd1: if (|(d & M_S1)) f = fmt(1'b1, ELEM_UBYTE, 3'd4, 1'b1, 5'd4);
         4'd2: if (|(d & M_S2)) f = fmt(1'b1, ELEM_UBYTE, 3'd4, 1'b1, 5'd4);
         4'd6: begin
            if (half) begin
               case (mode)
                  3'd1:    f = fmt(1'b1, ELEM_HALF, 3'd2, 1'b0, 5'd4);
                  3'd2, 3'd3, 3'd4:
                           f = fmt(1'b1, ELEM_HALF, 3'd4, 1'b0, 5'd8);
                  default: f = '0;
               endcase
            end else begin
               case (mode)
                  3'd1, 3'd5: f = fmt(1'b1, ELEM_FLOAT, 3'd2, 1'b0, 5'd8);
                  3'd2, 3'd3, 3'd4:
                              f = fmt(1'b1, ELEM_FLOAT, 3'd4, 1'b0, 5'd16);
                  default:    f = '0;
               endcase
            end
         end
         4'd7: begin
            if (half) begin
               case (mode)
                  3'd3:    f = fmt(1'b1, ELEM_HALF, 3'd2, 1'b0, 5'd4);
                  3'd4:    f = fmt(1'b1, ELEM_HALF, 3'd4, 1'b0, 5'd8);
                  default: f = '0;
               endcase
            end else begin
               case (mode)
                  3'd3, 3'd5: f = fmt(1'b1, ELEM_FLOAT, 3'd2, 1'b0, 5'd8);
                  3'd4:       f = fmt(1'b1, ELEM_FLOAT, 3'd4, 1'b0, 5'd16);
                  default:    f = '0;
               endcase
            end
         end
         4'd10: begin
            if (|(d & M_S10_PACK)) f = fmt(1'b1, ELEM_UBYTE, 3'd4, 1'b1, 5'd4);
            else if (|(d & M_S10_FLT)) f = fmt(1'b1, ELEM_FLOAT, 3'd2, 1'b0, 5'd8);
         end
         4'd11: begin
            if (|(d & M_S11_PACK)) f = fmt(1'b1, ELEM_UBYTE, 3'd4, 1'b0, 5'd4);
            else if (|(d & M_S11_FLT)) f = fmt(1'b1, ELEM_FLOAT, 3'd3, 1'b0, 5'd12);
         end
         4'd8, 4'd9: if (|(d & M_S8_S9)) f = fmt(1'b1, ELEM_UBYTE, 3'd4, 1'b1, 5'd4);
         4'd12: if (|(d & M_S12)) f = fmt(1'b1, ELEM_FLOAT, 3'd3, 1'b0, 5'd0);
         default: f = '0;
      endcase
      return f;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/vlc_if.sv =====
// Interfaces: request and response channels of the layout cache.
`timescale 1ns / 1ps
`default_nettype none
interface vlc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] descriptor;
   modport source (output valid, output descriptor, input ready);
   modport sink   (input valid, input descriptor, output ready);
endinterface

interface vlc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [7:0] entry_index;
   logic [3:0] slot;
   logic [1:0] elem_type;
   logic [2:0] components;
   logic       normalized;
   logic [6:0] byte_offset;
   logic [6:0] stride;
   logic       separate_stream;
   logic       last;
   modport source (output valid, output status, output entry_index, output slot,
                   output elem_type, output components, output normalized,
                   output byte_offset, output stride, output separate_stream,
                   output last, input ready);
   modport sink   (input valid, input status, input entry_index, input slot,
                   input elem_type, input components, input normalized,
                   input byte_offset, input stride, input separate_stream,
                   input last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/vertex_layout_cache_core.sv =====
// Top level: vertex layout cache with a row of search cells and a layout walker.
//
//   channel | dir | fields
//   req     | in  | descriptor[31:0]
//   rsp     | out | status, entry_index, slot, elem_type, components, normalized,
//           |     | byte_offset, stride, separate_stream, last
//
// A request runs a search while the hit token runs down the cell row, then steps
// through the 13 slots, one slot per cycle while the response register is not stalled,
// emitting the enabled ones, or emits a single response when the table is full.
// The offset walk overlaps the search.
// A new request is taken once the emit sequence has finished.
// Reset clears the entry count and control; stored keys are never read before written.
// A stalled response register holds the emit sequence in place.
`timescale 1ns / 1ps
`default_nettype none
module vertex_layout_cache_core
   import vlc_pkg::*;
#(
   parameter int TABLE_ENTRIES = VLC_TABLE_ENTRIES
) (
   input  wire logic clock,
   input  wire logic reset,
   vlc_req_if.sink   req,
   vlc_rsp_if.source rsp
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_EMIT   = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [31:0]      desc_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [3:0]       sp_ff, sp_in;
   logic             full_ff, full_in;
   logic [1:0]       status_ff, status_in;
   logic [IDX_W-1:0] index_ff, index_in;
   logic             write_req;

   logic             found   [TABLE_ENTRIES+1];
   logic [IDX_W-1:0] chain_ix [TABLE_ENTRIES+1];

   lay_stat_type     lay;
   logic             lay_start;

   // response register
   logic       rsp_valid_ff;
   logic [1:0] o_status_ff;
   logic [7:0] o_index_ff;
   logic [3:0] o_slot_ff;
   logic [1:0] o_type_ff;
   logic [2:0] o_comps_ff;
   logic       o_norm_ff;
   logic [6:0] o_off_ff;
   logic [6:0] o_stride_ff;
   logic       o_sep_ff;
   logic       o_last_ff;
   logic       out_free;
   logic       load_full, load_slot;
   logic [12:0] above;

   // search cell row
   assign found[0]    = 1'b0;
   assign chain_ix[0] = '0;

   for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
      vlc_cell #(.IDX_W(IDX_W)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .write_en    (write_req && (count_ff == CNT_W'(k))),
         .key         (desc_ff),
         .entry_valid (CNT_W'(k) < count_ff),
         .own_index   (IDX_W'(k)),
         .found_in    (found[k]),
         .index_in    (chain_ix[k]),
         .found_out   (found[k+1]),
         .index_out   (chain_ix[k+1])
      );
   end

   // layout walker
   assign lay_start = (state_ff == ST_SEARCH) && (cnt_ff == '0);

   vlc_layout u_layout (
      .clock (clock),
      .reset (reset),
      .start (lay_start),
      .desc  (desc_ff),
      .sel   (sp_ff),
      .stat  (lay)
   );

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign above    = lay.en >> sp_ff;

   // control sequence
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      cnt_in    = cnt_ff;
      sp_in     = sp_ff;
      full_in   = full_ff;
      status_in = status_ff;
      index_in  = index_ff;
      write_req = 1'b0;
      load_full = 1'b0;
      load_slot = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               state_in = ST_SEARCH;
               cnt_in   = '0;
            end
         end
         ST_SEARCH: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(TABLE_ENTRIES)) begin
               state_in = ST_EMIT;
               sp_in    = '0;
               full_in  = 1'b0;
               if (found[TABLE_ENTRIES]) begin
                  status_in = STATUS_FOUND;
                  index_in  = chain_ix[TABLE_ENTRIES];
               end else if (count_ff == CNT_W'(TABLE_ENTRIES)) begin
                  status_in = STATUS_FULL;
                  full_in   = 1'b1;
               end else begin
                  status_in = STATUS_ADDED;
                  index_in  = IDX_W'(count_ff);
                  write_req = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
               end
            end
         end
         ST_EMIT: begin
            if (full_ff) begin
               if (out_free) begin
                  load_full = 1'b1;
                  state_in  = ST_IDLE;
               end
            end else if (!lay.busy && (!lay.en[sp_ff] || out_free)) begin
               load_slot = lay.en[sp_ff];
               if (sp_ff == SLOT_SEPARATE) state_in = ST_IDLE;
               else sp_in = sp_ff + 4'd1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         cnt_ff   <= '0;
         sp_ff    <= '0;
         full_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         cnt_ff   <= cnt_in;
         sp_ff    <= sp_in;
         full_ff  <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      index_ff  <= index_in;
      if ((state_ff == ST_IDLE) && req.valid) desc_ff <= req.descriptor;
   end

   // response register load
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (load_full || load_slot) rsp_valid_ff <= 1'b1;
      else if (rsp.ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (load_full) begin
         o_status_ff <= STATUS_FULL;
         o_index_ff  <= '0;
         o_slot_ff   <= '0;
         o_type_ff   <= '0;
         o_comps_ff  <= '0;
         o_norm_ff   <= 1'b0;
         o_off_ff    <= '0;
         o_stride_ff <= '0;
         o_sep_ff    <= 1'b0;
         o_last_ff   <= 1'b1;
      end else if (load_slot) begin
         o_status_ff <= status_ff;
         o_index_ff  <= 8'(index_ff);
         o_slot_ff   <= sp_ff;
         o_type_ff   <= lay.rec.elem_type;
         o_comps_ff  <= lay.rec.comps;
         o_norm_ff   <= lay.rec.norm;
         o_off_ff    <= lay.rec.offset;
         o_stride_ff <= (sp_ff == SLOT_SEPARATE) ? 7'd12 : lay.stride;
         o_sep_ff    <= (sp_ff == SLOT_SEPARATE);
         o_last_ff   <= (above[12:1] == '0);
      end
   end

   assign req.ready           = (state_ff == ST_IDLE);
   assign rsp.valid           = rsp_valid_ff;
   assign rsp.status          = o_status_ff;
   assign rsp.entry_index     = o_index_ff;
   assign rsp.slot            = o_slot_ff;
   assign rsp.elem_type       = o_type_ff;
   assign rsp.components      = o_comps_ff;
   assign rsp.normalized      = o_norm_ff;
   assign rsp.byte_offset     = o_off_ff;
   assign rsp.stride          = o_stride_ff;
   assign rsp.separate_stream = o_sep_ff;
   assign rsp.last            = o_last_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/vlc_cell.sv =====
// Search cell: holds one stored key and passes the hit token to its neighbor.
`timescale 1ns / 1ps
`default_nettype none
module vlc_cell
   import vlc_pkg::*;
#(
   parameter int IDX_W = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             write_en,
   input  wire logic [31:0]      key,
   input  wire logic             entry_valid,
   input  wire logic [IDX_W-1:0] own_index,
   input  wire logic             found_in,
   input  wire logic [IDX_W-1:0] index_in,
   output logic                  found_out,
   output logic [IDX_W-1:0]      index_out
);

   logic [31:0]      key_ff;
   logic             found_ff;
   logic [IDX_W-1:0] index_ff;
   logic             match;

   assign match = entry_valid && (key_ff == key);

   // key storage
   always_ff @(posedge clock) begin
      if (write_en) key_ff <= key;
   end

   // hit token, first match upstream wins
   always_ff @(posedge clock) begin
      if (reset) found_ff <= 1'b0;
      else       found_ff <= found_in | match;
   end

   always_ff @(posedge clock) begin
      index_ff <= found_in ? index_in : own_index;
   end

   assign found_out = found_ff;
   assign index_out = index_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/vlc_layout.sv =====
// Layout unit: walks slots in offset order, keeps offsets, gives one slot record.
`timescale 1ns / 1ps
`default_nettype none
module vlc_layout
   import vlc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] desc,
   input  wire logic [3:0]  sel,
   output lay_stat_type     stat
);

   logic         busy_ff, busy_in;
   logic [3:0]   pos_ff, pos_in;
   logic [6:0]   acc_ff, acc_in;
   logic [6:0]   off_ff [VLC_WALK_LEN];
   logic [3:0]   walk_slot;
   slot_fmt_type walk_fmt;
   slot_fmt_type sel_fmt;
   logic [VLC_NUM_SLOTS-1:0] slot_en;

   assign walk_slot = WALK_ORDER[pos_ff];
   assign walk_fmt  = slot_fmt(desc, walk_slot);

   // walk control
   always_comb begin
      busy_in = busy_ff;
      pos_in  = pos_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         pos_in  = '0;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (walk_fmt.on) acc_in = acc_ff + 7'(walk_fmt.size);
         if (pos_ff == 4'(VLC_WALK_LEN - 1)) busy_in = 1'b0;
         else pos_in = pos_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (busy_ff && walk_fmt.on) off_ff[walk_slot] <= acc_ff;
   end

   // enable mask and the selected record
   always_comb begin
      for (int i = 0; i < VLC_NUM_SLOTS; i++) begin
         slot_en[i] = slot_fmt(desc, 4'(i)).on;
      end
   end

   assign sel_fmt              = slot_fmt(desc, sel);
   assign stat.en              = slot_en;
   assign stat.busy            = busy_ff;
   assign stat.stride          = acc_ff;
   assign stat.rec.elem_type   = sel_fmt.elem_type;
   assign stat.rec.comps       = sel_fmt.comps;
   assign stat.rec.norm        = sel_fmt.norm;
   assign stat.rec.offset      = (sel < 4'(VLC_WALK_LEN)) ? off_ff[sel] : 7'd0;

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench: vertex layout cache core, checked against a layout and lookup predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import vlc_pkg::*;

   localparam int ENTRIES   = VLC_TABLE_ENTRIES;
   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 400;
   localparam logic [31:0] TEX_MODE_SHIFT = 11;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] entry_index;
      logic [3:0] slot;
      logic [1:0] elem_type;
      logic [2:0] components;
      logic       normalized;
      logic [6:0] byte_offset;
      logic [6:0] stride;
      logic       separate_stream;
      logic       last;
   } layout_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   vlc_req_if req ();
   vlc_rsp_if rsp ();

   vertex_layout_cache_core u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [31:0]     key_table[$];
   layout_rsp_type  expected_layout[$];
   int              send_idle_pct  = 0;
   int              stall_pct      = 0;
   int              mismatch_count = 0;
   int              idle_cycles    = 0;

   // per-slot scratch for building one layout
   logic       sl_on   [13];
   logic [1:0] sl_type [13];
   logic [2:0] sl_comps[13];
   logic       sl_norm [13];
   logic [6:0] sl_off  [13];
   logic [6:0] run_off;

   function automatic void put_slot(int s, logic [1:0] et, int c, int n, int bytes);
      sl_on[s] = 1'b1; sl_type[s] = et; sl_comps[s] = 3'(c); sl_norm[s] = 1'(n);
      sl_off[s] = run_off;
      run_off = run_off + 7'(bytes);
   endfunction

   // lookup/append the key and queue the layout it produces
   function automatic void predict_layout(logic [31:0] d);
      int             idx;
      logic [1:0]     st;
      logic [2:0]     mode;
      layout_rsp_type r;
      idx  = -1;
      mode = d[13:11];
      for (int i = 0; i < key_table.size(); i++)
         if (idx < 0 && key_table[i] == d) idx = i;
      if (idx >= 0) begin
         st = STATUS_FOUND;
      end else if (key_table.size() >= ENTRIES) begin
         r = '0;
         r.status = STATUS_FULL;
         r.last = 1'b1;
         expected_layout.push_back(r);
         return;
      end else begin
         st  = STATUS_ADDED;
         idx = key_table.size();
         key_table.push_back(d);
      end
      for (int s = 0; s < 13; s++) sl_on[s] = 1'b0;
      run_off = '0;
      put_slot(0, ELEM_FLOAT, 3, 0, 12);
      if (|(d & 32'h0088_0008)) put_slot(3, ELEM_UBYTE, 4, 1, 4);
      else if (d[2]) put_slot(3, ELEM_FLOAT, 3, 0, 12);
      if (|(d & 32'h0100_0020)) put_slot(4, ELEM_UBYTE, 4, 1, 4);
      else if (d[4]) put_slot(4, ELEM_FLOAT, 3, 0, 12);
      if (|(d & 32'h0200_0080)) put_slot(5, ELEM_UBYTE, 4, 1, 4);
      else if (d[6]) put_slot(5, ELEM_FLOAT, 3, 0, 12);
      if (d[8]) put_slot(1, ELEM_UBYTE, 4, 1, 4);
      if (|d[10:9]) put_slot(2, ELEM_UBYTE, 4, 1, 4);
      // texture coordinates: half-float and float variants
      if (d[27]) begin
         case (mode)
            3'd1: put_slot(6, ELEM_HALF, 2, 0, 4);
            3'd2: put_slot(6, ELEM_HALF, 4, 0, 8);
            3'd3: begin put_slot(6, ELEM_HALF, 4, 0, 8); put_slot(7, ELEM_HALF, 2, 0, 4); end
            3'd4: begin put_slot(6, ELEM_HALF, 4, 0, 8); put_slot(7, ELEM_HALF, 4, 0, 8); end
            default: ;
         endcase
      end else begin
         case (mode)
            3'd1: put_slot(6, ELEM_FLOAT, 2, 0, 8);
            3'd2: put_slot(6, ELEM_FLOAT, 4, 0, 16);
            3'd3: begin put_slot(6, ELEM_FLOAT, 4, 0, 16); put_slot(7, ELEM_FLOAT, 2, 0, 8); end
            3'd4: begin put_slot(6, ELEM_FLOAT, 4, 0, 16); put_slot(7, ELEM_FLOAT, 4, 0, 16); end
            3'd5: begin put_slot(6, ELEM_FLOAT, 2, 0, 8); put_slot(7, ELEM_FLOAT, 2, 0, 8); end
            default: ;
         endcase
      end
      if (d[15]) put_slot(10, ELEM_UBYTE, 4, 1, 4);
      else if (d[14]) put_slot(10, ELEM_FLOAT, 2, 0, 8);
      if (d[17]) put_slot(11, ELEM_UBYTE, 4, 0, 4);
      else if (d[16]) put_slot(11, ELEM_FLOAT, 3, 0, 12);
      if (d[26]) begin
         put_slot(8, ELEM_UBYTE, 4, 1, 4);
         put_slot(9, ELEM_UBYTE, 4, 1, 4);
      end
      // separate stream: fixed offset and stride
      if (d[22]) begin
         sl_on[12] = 1'b1; sl_type[12] = ELEM_FLOAT; sl_comps[12] = 3'd3;
         sl_norm[12] = 1'b0; sl_off[12] = '0;
      end
      for (int s = 0; s < 13; s++) begin
         if (sl_on[s]) begin
            r.status          = st;
            r.entry_index     = 8'(idx);
            r.slot            = 4'(s);
            r.elem_type       = sl_type[s];
            r.components      = sl_comps[s];
            r.normalized      = sl_norm[s];
            r.byte_offset     = sl_off[s];
            r.stride          = (s == 12) ? 7'd12 : run_off;
            r.separate_stream = (s == 12);
            r.last            = 1'b0;
            expected_layout.push_back(r);
         end
      end
      expected_layout[expected_layout.size() - 1].last = 1'b1;
   endfunction

   // receiver stall pattern
   always @(posedge clock) begin
      rsp.ready <= ($urandom_range(99) >= stall_pct);
   end

   // response check and watchdog
   always @(posedge clock) begin
      layout_rsp_type got, exp_r;
      got = {rsp.status, rsp.entry_index, rsp.slot, rsp.elem_type, rsp.components,
             rsp.normalized, rsp.byte_offset, rsp.stride, rsp.separate_stream, rsp.last};
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_layout.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected transaction: %p", got);
         end else begin
            exp_r = expected_layout.pop_front();
            if (got !== exp_r) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %p, actual %p", exp_r, got);
            end
         end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[vertex_layout_cache_core] ERROR");
         $finish;
      end
   end

   // one request transaction, predicted on acceptance
   task automatic send_desc(logic [31:0] d);
      if ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req.valid      <= 1'b1;
      req.descriptor <= d;
      do @(posedge clock); while (!req.ready);
      predict_layout(d);
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      while (expected_layout.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_desc();
      case ($urandom_range(3))
         0:       return $urandom();
         1:       return $urandom() & $urandom();
         2:       return ($urandom() & 32'h0fc7_c7ff) | (32'($urandom_range(7)) << TEX_MODE_SHIFT);
         default: return $urandom() & $urandom() & $urandom();
      endcase
   endfunction

   // extremes, every texture mode with and without half float, each slot flag
   task automatic test_directed();
      send_desc(32'h0000_0000);
      send_desc(32'hffff_ffff);
      for (int m = 0; m < 8; m++) begin
         send_desc(32'(m) << TEX_MODE_SHIFT);
         send_desc((32'(m) << TEX_MODE_SHIFT) | 32'h0800_0000);
      end
      send_desc(32'h0000_0054);
      send_desc(32'h0388_00a8);
      send_desc(32'h0005_4700);
      send_desc(32'h044a_0000);
      send_desc(32'h0000_0000);   // hit on entry zero
      send_desc(32'hffff_ffff);
   endtask

   // random traffic with repeats, at the given sender idle and receiver stall percentages
   task automatic test_random(int count, int idle_p, int stall_p);
      send_idle_pct = idle_p;
      stall_pct     = stall_p;
      for (int i = 0; i < count; i++) begin
         if (key_table.size() > 0 && $urandom_range(99) < 30)
            send_desc(key_table[$urandom_range(key_table.size() - 1)]);
         else
            send_desc(rand_desc());
      end
   endtask

   // sender holds off until the cache has answered everything
   task automatic test_holdoff();
      wait_drained();
      send_desc(32'h0040_0000);
      wait_drained();
   endtask

   // table full: new keys are refused, stored keys still hit
   task automatic test_table_full();
      send_idle_pct = 0;
      stall_pct     = 26;
      while (key_table.size() < ENTRIES) send_desc($urandom());
      for (int i = 0; i < 8; i++) send_desc($urandom());
      send_desc(key_table[ENTRIES - 1]);
      send_desc(key_table[0]);
   endtask

   initial begin
      req.valid      = 1'b0;
      req.descriptor = '0;
      rsp.ready      = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(100, 0, 0);
      test_holdoff();
      test_random(100, 69, 0);
      test_random(100, 0, 69);
      test_random(100, 26, 26);
      test_table_full();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[vertex_layout_cache_core] OK");
      end else begin
         $display("[vertex_layout_cache_core] ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
